### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions of the rational arithmetic unit
// Operation codes, default width and the reduction phase type.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int RAU_WIDTH = 16;

   localparam logic [3:0] KIND_NORM = 4'd0;
   localparam logic [3:0] KIND_ADD  = 4'd1;
   localparam logic [3:0] KIND_SUB  = 4'd2;
   localparam logic [3:0] KIND_MUL  = 4'd3;
   localparam logic [3:0] KIND_DIV  = 4'd4;
   localparam logic [3:0] KIND_LT   = 4'd5;
   localparam logic [3:0] KIND_GT   = 4'd6;
   localparam logic [3:0] KIND_EQ   = 4'd7;
   localparam logic [3:0] KIND_LE   = 4'd8;
   localparam logic [3:0] KIND_GE   = 4'd9;
   localparam logic [3:0] KIND_NE   = 4'd10;

   // flag positions in the result tuser
   localparam int FLAG_CMP = 0;
   localparam int FLAG_ERR = 1;
   localparam int FLAG_OVF = 2;

   typedef enum logic [1:0] {
      PH_A   = 2'd0,
      PH_B   = 2'd1,
      PH_INV = 2'd2,
      PH_R   = 2'd3
   } phase_type;

endpackage

### rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction arithmetic with GCD reduction
// Normalize, add, subtract, multiply, divide and compare signed fractions.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation: kind in tuser, the two fractions in
//   tdata. rsp channel returns one reduced fraction plus flags per transfer.
//   req_tready is high only while the unit is idle; one operation at a time.
//   Every fraction reduction with nonzero numerator and denominator runs
//   Euclid's GCD on a shared restoring divider, followed by two divisions
//   by the GCD. An operation does up to four reductions and three passes
//   through one shared multiplier; unused kinds go straight to the final
//   state, and operands with long Euclid chains take the longest.
//   The result sits in an output register; a stalled receiver holds the
//   unit in its final state until the pending result is taken.
//   Reset (synchronous) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WIDTH = RAU_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // a_num, a_den, b_num, b_den
   input  logic [((4*WIDTH-1+7)/8)*8-1:0]        req_tdata,
   // kind
   input  logic [3:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // res_num, res_den
   output logic [((2*WIDTH-1+7)/8)*8-1:0]        rsp_tdata,
   // cmp_true, zero_den_error, overflow
   output logic [2:0]                            rsp_tuser
);

   localparam int W      = WIDTH;
   localparam int M      = 2 * W;
   localparam int SW     = 2 * W + 1;
   localparam int RSP_DW = ((2 * W - 1 + 7) / 8) * 8;

   localparam logic signed [SW-1:0] LIM_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] LIM_LO = ~LIM_HI;
   localparam logic signed [SW-1:0] ONE    = SW'(1);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_LOAD   = 11'b00000000010,
      S_GCD    = 11'b00000000100,
      S_GCD_W  = 11'b00000001000,
      S_DIVN   = 11'b00000010000,
      S_DIVN_W = 11'b00000100000,
      S_DIVD   = 11'b00001000000,
      S_DIVD_W = 11'b00010000000,
      S_STORE  = 11'b00100000000,
      S_MUL    = 11'b01000000000,
      S_FIN    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [3:0] kind_ff, kind_in;
   logic signed [W-1:0] ia_num_ff, ia_num_in, ia_den_ff, ia_den_in, ib_num_ff, ib_num_in;
   logic [W-2:0] ib_den_ff, ib_den_in;
   logic signed [SW-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic signed [SW-1:0] vn_ff, vn_in, vd_ff, vd_in, rn_ff, rn_in, rd_ff, rd_in;
   logic signed [SW-1:0] fn_ff, fn_in, fd_ff, fd_in;
   logic signed [SW-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [M-1:0] mn_ff, mn_in, md_ff, md_in, ga_ff, ga_in, gb_ff, gb_in, qn_ff, qn_in;
   logic neg_ff, neg_in, err_ff, err_in;
   logic [1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_num_ff, rsp_num_in;
   logic [W-2:0] rsp_den_ff, rsp_den_in;
   logic [2:0] rsp_flags_ff, rsp_flags_in;

   logic signed [SW-1:0] ld_n, ld_d, out_n, out_d;
   logic signed [W:0] mop1, mop2;
   logic signed [2*W+1:0] prod;
   logic [SW-1:0] abs_n, abs_d;
   logic cmp;
   logic div_start, div_done;
   logic [M-1:0] div_dividend, div_divisor, div_quo, div_rem;

   rau_divider #(.N(M)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // reduction source operands
   always_comb begin
      case (phase_ff)
         PH_A: begin
            ld_n = SW'(ia_num_ff);
            ld_d = SW'(ia_den_ff);
         end
         PH_B: begin
            ld_n = SW'(ib_num_ff);
            ld_d = $signed({{(SW-W+1){1'b0}}, ib_den_ff});
         end
         PH_INV: begin
            ld_n = bd_ff;
            ld_d = bn_ff;
         end
         default: begin
            ld_n = (kind_ff == KIND_ADD) ? p0_ff + p1_ff :
                   (kind_ff == KIND_SUB) ? p0_ff - p1_ff : p0_ff;
            ld_d = p2_ff;
         end
      endcase
      abs_n = ld_n[SW-1] ? -ld_n : ld_n;
      abs_d = ld_d[SW-1] ? -ld_d : ld_d;
   end

   // shared multiplier operands
   always_comb begin
      case (cnt_ff)
         2'd0: begin
            mop1 = an_ff[W:0];
            mop2 = (kind_ff == KIND_MUL) ? bn_ff[W:0] :
                   (kind_ff == KIND_DIV) ? vn_ff[W:0] : bd_ff[W:0];
         end
         2'd1: begin
            mop1 = bn_ff[W:0];
            mop2 = ad_ff[W:0];
         end
         default: begin
            mop1 = ad_ff[W:0];
            mop2 = (kind_ff == KIND_DIV) ? vd_ff[W:0] : bd_ff[W:0];
         end
      endcase
      prod = mop1 * mop2;
   end

   always_comb begin
      case (kind_ff)
         KIND_LT: cmp = p0_ff <  p1_ff;
         KIND_GT: cmp = p0_ff >  p1_ff;
         KIND_EQ: cmp = p0_ff == p1_ff;
         KIND_LE: cmp = p0_ff <= p1_ff;
         KIND_GE: cmp = p0_ff >= p1_ff;
         KIND_NE: cmp = p0_ff != p1_ff;
         default: cmp = 1'b0;
      endcase
      if (kind_ff == KIND_NORM) begin
         out_n = an_ff;
         out_d = ad_ff;
      end else if (kind_ff <= KIND_DIV) begin
         out_n = rn_ff;
         out_d = rd_ff;
      end else begin
         out_n = '0;
         out_d = ONE;
      end
   end

   assign div_start    = ((state_ff == S_GCD) && (gb_ff != '0)) ||
                         (state_ff == S_DIVN) || (state_ff == S_DIVD);
   assign div_dividend = (state_ff == S_GCD) ? ga_ff :
                         (state_ff == S_DIVN) ? mn_ff : md_ff;
   assign div_divisor  = (state_ff == S_GCD) ? gb_ff : ga_ff;

   always_comb begin
      state_in = state_ff;   phase_in = phase_ff;   kind_in = kind_ff;
      ia_num_in = ia_num_ff; ia_den_in = ia_den_ff;
      ib_num_in = ib_num_ff; ib_den_in = ib_den_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      vn_in = vn_ff; vd_in = vd_ff; rn_in = rn_ff; rd_in = rd_ff;
      fn_in = fn_ff; fd_in = fd_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff;
      mn_in = mn_ff; md_in = md_ff; ga_in = ga_ff; gb_in = gb_ff; qn_in = qn_ff;
      neg_in = neg_ff; err_in = err_ff; cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_num_in = rsp_num_ff; rsp_den_in = rsp_den_ff; rsp_flags_in = rsp_flags_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               ia_num_in = req_tdata[W-1:0];
               ia_den_in = req_tdata[2*W-1:W];
               ib_num_in = req_tdata[3*W-1:2*W];
               ib_den_in = req_tdata[4*W-2:3*W];
               err_in    = 1'b0;
               phase_in  = PH_A;
               state_in  = (req_tuser > KIND_NE) ? S_FIN : S_LOAD;
            end
         end
         S_LOAD: begin
            if (ld_n == '0) begin
               fn_in    = '0;
               fd_in    = ONE;
               state_in = S_STORE;
            end else if (ld_d == '0) begin
               fn_in    = ONE;
               fd_in    = ONE;
               err_in   = 1'b1;
               state_in = S_STORE;
            end else begin
               mn_in    = abs_n[M-1:0];
               md_in    = abs_d[M-1:0];
               ga_in    = abs_n[M-1:0];
               gb_in    = abs_d[M-1:0];
               neg_in   = ld_n[SW-1] ^ ld_d[SW-1];
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            state_in = (gb_ff == '0) ? S_DIVN : S_GCD_W;
         end
         S_GCD_W: begin
            if (div_done) begin
               ga_in    = gb_ff;
               gb_in    = div_rem;
               state_in = S_GCD;
            end
         end
         S_DIVN: begin
            state_in = S_DIVN_W;
         end
         S_DIVN_W: begin
            if (div_done) begin
               qn_in    = div_quo;
               state_in = S_DIVD;
            end
         end
         S_DIVD: begin
            state_in = S_DIVD_W;
         end
         S_DIVD_W: begin
            if (div_done) begin
               fn_in    = neg_ff ? -$signed({1'b0, qn_ff}) : $signed({1'b0, qn_ff});
               fd_in    = $signed({1'b0, div_quo});
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cnt_in = 2'd0;
            case (phase_ff)
               PH_A: begin
                  an_in = fn_ff;
                  ad_in = fd_ff;
                  phase_in = PH_B;
                  state_in = (kind_ff == KIND_NORM) ? S_FIN : S_LOAD;
               end
               PH_B: begin
                  bn_in = fn_ff;
                  bd_in = fd_ff;
                  phase_in = PH_INV;
                  state_in = (kind_ff == KIND_DIV) ? S_LOAD : S_MUL;
               end
               PH_INV: begin
                  vn_in = fn_ff;
                  vd_in = fd_ff;
                  state_in = S_MUL;
               end
               default: begin
                  rn_in = fn_ff;
                  rd_in = fd_ff;
                  state_in = S_FIN;
               end
            endcase
         end
         S_MUL: begin
            case (cnt_ff)
               2'd0:    p0_in = prod[SW-1:0];
               2'd1:    p1_in = prod[SW-1:0];
               default: p2_in = prod[SW-1:0];
            endcase
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               phase_in = PH_R;
               state_in = (kind_ff <= KIND_DIV) ? S_LOAD : S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = out_n[W-1:0];
               rsp_den_in   = out_d[W-2:0];
               rsp_flags_in[FLAG_CMP] = cmp;
               rsp_flags_in[FLAG_ERR] = err_ff;
               rsp_flags_in[FLAG_OVF] = (kind_ff <= KIND_DIV) &&
                  ((out_n < LIM_LO) || (out_n > LIM_HI) || (out_d > LIM_HI));
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;   kind_ff <= kind_in;
      ia_num_ff <= ia_num_in; ia_den_ff <= ia_den_in;
      ib_num_ff <= ib_num_in; ib_den_ff <= ib_den_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      vn_ff <= vn_in; vd_ff <= vd_in; rn_ff <= rn_in; rd_ff <= rd_in;
      fn_ff <= fn_in; fd_ff <= fd_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in;
      mn_ff <= mn_in; md_ff <= md_in; ga_ff <= ga_in; gb_ff <= gb_in; qn_ff <= qn_in;
      neg_ff <= neg_in; err_ff <= err_in; cnt_ff <= cnt_in;
      rsp_num_ff <= rsp_num_in; rsp_den_ff <= rsp_den_in; rsp_flags_ff <= rsp_flags_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-2*W+1){1'b0}}, rsp_den_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_flags_ff;

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("unit still ready after accepting an operation");

   a_cmp_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff[FLAG_CMP]) |->
         (rsp_num_ff == '0) && !rsp_flags_ff[FLAG_OVF])
      else $error("comparison result carries a fraction or overflow");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == S_GCD_W) || (state_ff == S_DIVN_W) ||
                    (state_ff == S_DIVD_W)))
      else $error("divider finished while sequencer was not waiting");

endmodule

### rtl/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider: restoring unsigned divider
// One quotient bit per cycle; done flags the quotient and remainder.
// ----------------------------------------------------------------------------
module rau_divider
   import rau_pkg::*;
#(
   parameter int N = 2 * RAU_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [N-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient,
   output logic [N-1:0] remainder
);

   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  quo_ff, quo_in;
   logic [N-1:0]  rem_ff, rem_in;
   logic [N-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [N:0]    rem_sh;
   logic [N:0]    diff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[N-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(N);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[N-2:0], ~diff[N]};
         rem_in = diff[N] ? rem_sh[N-1:0] : diff[N-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
